FILE: sv/tcm_pkg.sv
// Package with the request and response types and the constants of the timestamp clock mapper.
package tcm_pkg;

   // Clock tags as carried in the request and reported in the response.
   typedef enum logic [1:0] {
      CLK_UNKNOWN   = 2'd0,
      CLK_REALTIME  = 2'd1,
      CLK_MONOTONIC = 2'd2,
      CLK_OTHER     = 2'd3
   } tcm_clock_type;

   // Handling of a request whose clock tag is unknown.
   typedef enum logic [1:0] {
      POLICY_REJECT    = 2'd0,
      POLICY_REALTIME  = 2'd1,
      POLICY_MONOTONIC = 2'd2,
      POLICY_SPARE     = 2'd3
   } tcm_policy_type;

   // Register indexes of the control port.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_UNKNOWN_POLICY      = 3'd0,
      CSR_HOST_REALTIME_NS    = 3'd1,
      CSR_HOST_MONOTONIC_NS   = 3'd2,
      CSR_HOST_UNCERTAINTY_NS = 3'd3,
      CSR_HOST_SAMPLE_OK      = 3'd4
   } tcm_csr_index_type;

   localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
   // Largest representable wall-clock time: (2^32-1) seconds plus 999999999 ns.
   localparam logic [62:0] MAX_MAPPED_NS = 63'd4294967295999999999;

   typedef struct packed {
      logic signed [63:0] stamp_seconds;
      logic [31:0]        stamp_nanos;
      logic [1:0]         stamp_clock;
   } tcm_req_type;

   typedef struct packed {
      logic               map_ok;
      logic [1:0]         used_clock;
      logic [62:0]        source_total_ns;
      logic signed [63:0] offset_ns;
      logic [62:0]        mapped_ns;
      logic [63:0]        error_bound_ns;
   } tcm_rsp_type;

endpackage

FILE: sv/timestamp_clock_mapper.sv
// Top level of the timestamp clock mapper: a five-register pipeline from camera stamp to wall time.
//
// Usage
// The request channel (req_valid, req_ready, req_data) takes one camera timestamp per request:
// signed seconds, nanoseconds and a clock tag. The response channel (rsp_valid, rsp_ready,
// rsp_data) returns exactly one result per request, in request order.
// The control channel (csr_valid, csr_ready, csr_index, csr_wdata) writes the unknown-clock
// policy and the host clock pair; it is always ready and must only be used while no request is
// in flight. Writes to an index beyond the register list are ignored.
// A request taken into the first register moves through the other four in order to the
// response register; one request per cycle is taken while the receiver takes responses.
// The pipeline has five registers (the low 32 and next 31 bits of the seconds form two partial
// products with 1e9 in the first, the partial sums are added over the next two, the host offset is
// added in the fourth and the final range check and result selection load the response register).
// Each stage has its own valid bit and loads whenever the stage after it is empty or moving,
// so bubbles close up and a request is taken while a finished response still waits.
// When the receiver stalls, the response stays valid and unchanged and the stages behind it
// fill up; req_ready falls only once all five are occupied. Nothing is lost or repeated.
// Reset clears every valid bit and all control registers, which gives a reject policy, a zero
// host pair and a host sample marked invalid.
module timestamp_clock_mapper
   import tcm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tcm_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tcm_rsp_type                rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                csr_wdata
);

   // ------------------------------------------------------------------
   // Control registers.
   // ------------------------------------------------------------------
   tcm_policy_type     policy_ff;
   logic [62:0]        host_rt_ff;
   logic [62:0]        host_mono_ff;
   logic [63:0]        host_unc_ff;
   logic               host_ok_ff;
   logic signed [63:0] offset_ff;
   logic signed [63:0] offset_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_REJECT;
         host_rt_ff   <= '0;
         host_mono_ff <= '0;
         host_unc_ff  <= '0;
         host_ok_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (tcm_csr_index_type'(csr_index))
            CSR_UNKNOWN_POLICY:      policy_ff    <= tcm_policy_type'(csr_wdata[1:0]);
            CSR_HOST_REALTIME_NS:    host_rt_ff   <= csr_wdata[62:0];
            CSR_HOST_MONOTONIC_NS:   host_mono_ff <= csr_wdata[62:0];
            CSR_HOST_UNCERTAINTY_NS: host_unc_ff  <= csr_wdata;
            CSR_HOST_SAMPLE_OK:      host_ok_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Both samples are below 2^63, so the difference always fits a signed 64-bit value; it is
   // recomputed every cycle. Requests must follow a write only once idle; the block does not check.
   assign offset_in = $signed({1'b0, host_rt_ff}) - $signed({1'b0, host_mono_ff});

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or its
   // contents move on in the same cycle.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, rsp_valid_in;
   logic en1, en2, en3, en4, en5;

   assign en5 = !rsp_valid_ff || rsp_ready;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_ready = en1;

   assign s1_valid_in  = en1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = en2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = en3 ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in  = en4 ? s3_valid_ff : s4_valid_ff;
   assign rsp_valid_in = en5 ? s4_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: two partial products of seconds times 1e9, and the simple
   // rejections (negative seconds, nanoseconds of a full second or more).
   // ------------------------------------------------------------------
   logic [61:0] s1_pp_lo_ff, s1_pp_lo_in;
   logic [60:0] s1_pp_hi_ff, s1_pp_hi_in;
   logic [31:0] s1_nanos_ff;
   logic [1:0]  s1_clock_ff;
   logic        s1_bad_ff, s1_bad_in;

   assign s1_pp_lo_in = 62'(req_data.stamp_seconds[31:0]) * 62'(NS_PER_SEC);
   assign s1_pp_hi_in = 61'(req_data.stamp_seconds[62:32]) * 61'(NS_PER_SEC);
   assign s1_bad_in   = req_data.stamp_seconds[63] ||
                        (req_data.stamp_nanos >= 32'(NS_PER_SEC));

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_pp_lo_ff <= s1_pp_lo_in;
         s1_pp_hi_ff <= s1_pp_hi_in;
         s1_nanos_ff <= req_data.stamp_nanos;
         s1_clock_ff <= req_data.stamp_clock;
         s1_bad_ff   <= s1_bad_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: add the nanoseconds to the low product; the high product
   // must stay below 2^31, or the shifted sum cannot fit 63 bits.
   // ------------------------------------------------------------------
   logic [62:0] s2_lo_sum_ff, s2_lo_sum_in;
   logic [30:0] s2_hi_ff;
   logic [1:0]  s2_clock_ff;
   logic        s2_bad_ff, s2_bad_in;

   assign s2_lo_sum_in = {1'b0, s1_pp_lo_ff} + 63'(s1_nanos_ff);
   assign s2_bad_in    = s1_bad_ff || (s1_pp_hi_ff[60:31] != '0);

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_lo_sum_ff <= s2_lo_sum_in;
         s2_hi_ff     <= s1_pp_hi_ff[30:0];
         s2_clock_ff  <= s1_clock_ff;
         s2_bad_ff    <= s2_bad_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: source time in nanoseconds and the clock after the policy.
   // ------------------------------------------------------------------
   logic [63:0]   s3_sum;
   logic [62:0]   s3_src_ff;
   logic          s3_src_ok_ff, s3_src_ok_in;
   logic [1:0]    s3_clock_ff;
   tcm_clock_type s3_eff_ff, s3_eff_in;

   assign s3_sum       = {1'b0, s2_hi_ff, 32'd0} + {1'b0, s2_lo_sum_ff};
   assign s3_src_ok_in = !s2_bad_ff && !s3_sum[63];

   always_comb begin
      s3_eff_in = tcm_clock_type'(s2_clock_ff);
      if (tcm_clock_type'(s2_clock_ff) == CLK_UNKNOWN) begin
         priority if (policy_ff == POLICY_REALTIME) begin
            s3_eff_in = CLK_REALTIME;
         end else if (policy_ff == POLICY_MONOTONIC) begin
            s3_eff_in = CLK_MONOTONIC;
         end else begin
            s3_eff_in = CLK_UNKNOWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_src_ff    <= s3_sum[62:0];
         s3_src_ok_ff <= s3_src_ok_in;
         s3_clock_ff  <= s2_clock_ff;
         s3_eff_ff    <= s3_eff_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: add the host offset with one guard bit for the sign, and
   // check the source time against the representable range.
   // ------------------------------------------------------------------
   logic signed [64:0] s4_mapped_ff, s4_mapped_in;
   logic [62:0]        s4_src_ff;
   logic               s4_src_ok_ff;
   logic               s4_src_range_ff, s4_src_range_in;
   logic [1:0]         s4_clock_ff;
   tcm_clock_type      s4_eff_ff;

   assign s4_mapped_in    = $signed({2'b00, s3_src_ff}) + $signed({offset_ff[63], offset_ff});
   assign s4_src_range_in = (s3_src_ff <= MAX_MAPPED_NS);

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_mapped_ff    <= s4_mapped_in;
         s4_src_ff       <= s3_src_ff;
         s4_src_ok_ff    <= s3_src_ok_ff;
         s4_src_range_ff <= s4_src_range_in;
         s4_clock_ff     <= s3_clock_ff;
         s4_eff_ff       <= s3_eff_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: select the response fields into the response register.
   // ------------------------------------------------------------------
   tcm_rsp_type rsp_ff, rsp_in;
   logic        mono_fit;

   // The sum never exceeds 2^64, so a clear guard bit and a bound check cover every failure.
   assign mono_fit = !s4_mapped_ff[64] && (s4_mapped_ff[63:0] <= 64'(MAX_MAPPED_NS));

   always_comb begin
      rsp_in = '0;
      priority if (!s4_src_ok_ff) begin
         // Invalid source: only the original clock tag is reported.
         rsp_in.used_clock = s4_clock_ff;
      end else if (s4_eff_ff == CLK_REALTIME) begin
         // Realtime passes through; the time is shown even when out of range.
         rsp_in.map_ok          = s4_src_range_ff;
         rsp_in.used_clock      = CLK_REALTIME;
         rsp_in.source_total_ns = s4_src_ff;
         rsp_in.mapped_ns       = s4_src_ff;
      end else if (s4_eff_ff == CLK_MONOTONIC && host_ok_ff) begin
         // A monotonic failure zeroes every field, the clock included.
         if (mono_fit) begin
            rsp_in.map_ok          = 1'b1;
            rsp_in.used_clock      = CLK_MONOTONIC;
            rsp_in.source_total_ns = s4_src_ff;
            rsp_in.offset_ns       = offset_ff;
            rsp_in.mapped_ns       = s4_mapped_ff[62:0];
            rsp_in.error_bound_ns  = host_unc_ff;
         end
      end else begin
         // Rejected clock, or monotonic without a usable host sample.
         rsp_in.used_clock      = s4_eff_ff;
         rsp_in.source_total_ns = s4_src_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/tcm_checker.sv
// Port-level checker for the timestamp clock mapper and its bind to the top level.
module tcm_checker
   import tcm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input tcm_rsp_type rsp_data
);

   // No response is offered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A good mapping always comes from a realtime or monotonic clock and lies in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.map_ok |->
         (rsp_data.used_clock == CLK_REALTIME || rsp_data.used_clock == CLK_MONOTONIC) &&
         (rsp_data.mapped_ns <= MAX_MAPPED_NS))
      else $error("good mapping with bad clock or out of range");

   // Realtime responses carry the source time unchanged and no offset or error bound.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.used_clock == CLK_REALTIME |->
         rsp_data.mapped_ns == rsp_data.source_total_ns &&
         rsp_data.offset_ns == '0 && rsp_data.error_bound_ns == '0)
      else $error("realtime response altered");

   // A good monotonic mapping equals the source time plus the reported offset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.map_ok && rsp_data.used_clock == CLK_MONOTONIC |->
         65'($signed({2'b00, rsp_data.source_total_ns}) +
             $signed({rsp_data.offset_ns[63], rsp_data.offset_ns})) ==
         {2'b00, rsp_data.mapped_ns})
      else $error("monotonic mapping inconsistent with offset");

endmodule

bind timestamp_clock_mapper tcm_checker u_tcm_checker (.*);

FILE: bench/timestamp_clock_mapper_test.sv
// Self-checking testbench of the timestamp clock mapper with random handshakes and control writes.
module timestamp_clock_mapper_test;
   import tcm_pkg::*;

   // Limits used by the predictor when it checks the source time and the monotonic sum.
   localparam logic [63:0]        NS_PER_SEC_64 = {34'b0, NS_PER_SEC};
   localparam logic [63:0]        SOURCE_NS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SIGNED_NS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SIGNED_MAPPED_MAX = $signed({1'b0, MAX_MAPPED_NS});
   // An index past the end of the register list; the block must ignore writes to it.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INDEX_SPARE = 3'd7;
   // Percentage of cycles in which each side idles while random gaps are enabled.
   localparam int IDLE_PERCENT = 36;
   // The receiver stops taking responses for this long once, after this many responses.
   localparam int HOLD_AFTER = 400;
   localparam int HOLD_CYCLES = 120;
   localparam int RANDOM_PHASES = 6;
   localparam int STAMPS_PER_PHASE = 180;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   tcm_req_type                req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   tcm_rsp_type                rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [63:0]                csr_wdata = '0;

   // Requests waiting to be offered, and the responses that accepted requests must produce.
   tcm_req_type pending_stamps[$];
   tcm_rsp_type expected_maps[$];

   // Our own copy of the control registers, updated whenever a write is accepted.
   tcm_policy_type cfg_policy = POLICY_REJECT;
   logic [62:0]    cfg_wall_ns = '0;
   logic [62:0]    cfg_steady_ns = '0;
   logic [63:0]    cfg_uncertainty_ns = '0;
   logic           cfg_sample_ok = 1'b0;

   int  mismatch_count = 0;
   int  responses_seen = 0;
   int  hold_left = 0;
   // While set, neither side inserts idle cycles.
   logic gapless = 1'b0;

   timestamp_clock_mapper u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Works out the wall-clock mapping of one stamp under the current register settings.
   function automatic tcm_rsp_type map_stamp(input tcm_req_type stamp);
      logic [63:0]        secs;
      logic [63:0]        nanos;
      logic [63:0]        total_ns;
      logic signed [63:0] offset;
      logic signed [63:0] mapped;
      tcm_clock_type      clk;
      tcm_rsp_type        result;
      result = '0;
      secs = stamp.stamp_seconds;
      nanos = {32'b0, stamp.stamp_nanos};
      clk = tcm_clock_type'(stamp.stamp_clock);
      // A negative second count, an out-of-range nanosecond field or a product that does not
      // fit in 63 bits makes the source invalid; only the raw clock tag is reported.
      if (secs[63] || nanos >= NS_PER_SEC_64 || secs > (SOURCE_NS_MAX - nanos) / NS_PER_SEC_64) begin
         result.used_clock = clk;
         return result;
      end
      total_ns = secs * NS_PER_SEC_64 + nanos;
      if (clk == CLK_UNKNOWN) begin
         if (cfg_policy == POLICY_REALTIME) begin
            clk = CLK_REALTIME;
         end else if (cfg_policy == POLICY_MONOTONIC) begin
            clk = CLK_MONOTONIC;
         end
      end
      // Realtime passes through; the time is reported even when it is out of range.
      if (clk == CLK_REALTIME) begin
         result.map_ok = (total_ns <= {1'b0, MAX_MAPPED_NS});
         result.used_clock = clk;
         result.source_total_ns = total_ns[62:0];
         result.mapped_ns = total_ns[62:0];
         return result;
      end
      if (clk != CLK_MONOTONIC || !cfg_sample_ok) begin
         result.used_clock = clk;
         result.source_total_ns = total_ns[62:0];
         return result;
      end
      // Both host samples are below 2^63, so their difference always fits.
      offset = $signed({1'b0, cfg_wall_ns}) - $signed({1'b0, cfg_steady_ns});
      if (offset > 0 && $signed(total_ns) > SIGNED_NS_MAX - offset) begin
         return result;
      end
      mapped = $signed(total_ns) + offset;
      if (mapped < 0 || mapped > SIGNED_MAPPED_MAX) begin
         return result;
      end
      result.map_ok = 1'b1;
      result.used_clock = clk;
      result.source_total_ns = total_ns[62:0];
      result.offset_ns = offset;
      result.mapped_ns = mapped[62:0];
      result.error_bound_ns = cfg_uncertainty_ns;
      return result;
   endfunction

   function automatic tcm_req_type stamp_of(input logic [63:0] secs, input logic [31:0] nanos,
                                            input tcm_clock_type clk);
      tcm_req_type stamp;
      stamp.stamp_seconds = secs;
      stamp.stamp_nanos = nanos;
      stamp.stamp_clock = clk;
      return stamp;
   endfunction

   // Random stamps lean towards the interesting regions: ordinary times, the edge of the
   // representable range, the edge of 63-bit overflow, and a share of raw noise.
   function automatic tcm_req_type random_stamp();
      int          pick;
      logic [63:0] secs;
      logic [31:0] nanos;
      pick = $urandom_range(0, 99);
      nanos = $urandom_range(0, 999999999);
      if (pick < 45) begin
         secs = {32'b0, $urandom};
      end else if (pick < 60) begin
         secs = 64'd4294967293 + 64'($urandom_range(0, 4));
         nanos = $urandom_range(999990000, 999999999);
      end else if (pick < 70) begin
         secs = 64'd9223372035 + 64'($urandom_range(0, 2));
         nanos = $urandom_range(854775000, 854776000);
      end else if (pick < 88) begin
         secs = {$urandom, $urandom};
      end else begin
         secs = 64'($urandom_range(0, 1000));
         nanos = $urandom;
      end
      return stamp_of(secs, nanos, tcm_clock_type'($urandom_range(0, 3)));
   endfunction

   // Writes one control register and mirrors the write once the handshake completes.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] reg_index, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (reg_index)
         CSR_UNKNOWN_POLICY:      cfg_policy = tcm_policy_type'(value[1:0]);
         CSR_HOST_REALTIME_NS:    cfg_wall_ns = value[62:0];
         CSR_HOST_MONOTONIC_NS:   cfg_steady_ns = value[62:0];
         CSR_HOST_UNCERTAINTY_NS: cfg_uncertainty_ns = value;
         CSR_HOST_SAMPLE_OK:      cfg_sample_ok = value[0];
         default:                 ;
      endcase
   endtask

   task automatic write_host_pair(input tcm_policy_type policy, input logic [63:0] wall_ns,
                                  input logic [63:0] steady_ns, input logic [63:0] uncertainty,
                                  input logic [63:0] sample_ok);
      write_csr(CSR_UNKNOWN_POLICY, {62'b0, policy});
      write_csr(CSR_HOST_REALTIME_NS, wall_ns);
      write_csr(CSR_HOST_MONOTONIC_NS, steady_ns);
      write_csr(CSR_HOST_UNCERTAINTY_NS, uncertainty);
      write_csr(CSR_HOST_SAMPLE_OK, sample_ok);
   endtask

   // The registers may only change with nothing in flight. Every request yields exactly one
   // response, so an empty scoreboard means an empty pipeline.
   task automatic wait_drained();
      while (pending_stamps.size() != 0 || expected_maps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Request driver. A request that was offered and not taken is held unchanged; otherwise the
   // next pending stamp is offered unless a random idle cycle is drawn. The prediction is made
   // at the edge where the request is taken, from exactly what was on the bus.
   always @(posedge clock) begin
      logic offer;
      if (req_valid && req_ready) begin
         expected_maps.push_back(map_stamp(req_data));
         void'(pending_stamps.pop_front());
      end
      offer = req_valid && !req_ready;
      if (!offer && !reset && pending_stamps.size() != 0) begin
         offer = gapless || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
      if (offer) begin
         req_data <= pending_stamps[0];
      end
      req_valid <= offer;
   end

   task automatic check_field(input string field, input logic [63:0] wanted,
                              input logic [63:0] actual);
      if (wanted !== actual) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, wanted, actual);
      end
   endtask

   // Response monitor. Each response taken is compared field by field with the oldest
   // prediction. Once, after a fixed number of responses, the receiver holds off for a long
   // stretch so that the pipeline fills and the block has to drop req_ready.
   always @(posedge clock) begin
      tcm_rsp_type wanted;
      logic        next_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_maps.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with no request outstanding: expected none, actual %h",
                     $time, rsp_data);
         end else begin
            wanted = expected_maps.pop_front();
            check_field("map_ok", {63'b0, wanted.map_ok}, {63'b0, rsp_data.map_ok});
            check_field("used_clock", {62'b0, wanted.used_clock}, {62'b0, rsp_data.used_clock});
            check_field("source_total_ns", {1'b0, wanted.source_total_ns},
                        {1'b0, rsp_data.source_total_ns});
            check_field("offset_ns", wanted.offset_ns, rsp_data.offset_ns);
            check_field("mapped_ns", {1'b0, wanted.mapped_ns}, {1'b0, rsp_data.mapped_ns});
            check_field("error_bound_ns", wanted.error_bound_ns, rsp_data.error_bound_ns);
         end
         responses_seen++;
         if (responses_seen == HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else begin
         next_ready = !reset && (gapless || ($urandom_range(0, 99) >= IDLE_PERCENT));
      end
      rsp_ready <= next_ready;
   end

   // Stimulus: directed stamps under a handful of fixed settings, then random phases, each
   // starting from fresh random register contents.
   initial begin
      logic [63:0] monotonic_w;
      logic [63:0] realtime_w;
      logic [63:0] uncertainty_w;
      logic [63:0] sample_w;
      logic [31:0] step;
      int          kind;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: reject policy, host sample invalid. Covers the source checks, the
      // exact edges of the representable and 63-bit ranges, and every clock tag.
      pending_stamps.push_back(stamp_of(64'd0, 32'd0, CLK_REALTIME));
      pending_stamps.push_back(stamp_of(64'd4294967295, 32'd999999999, CLK_REALTIME));
      pending_stamps.push_back(stamp_of(64'd4294967296, 32'd0, CLK_REALTIME));
      pending_stamps.push_back(stamp_of(64'd9223372036, 32'd854775807, CLK_REALTIME));
      pending_stamps.push_back(stamp_of(64'd9223372036, 32'd854775808, CLK_REALTIME));
      pending_stamps.push_back(stamp_of(SOURCE_NS_MAX, 32'd0, CLK_MONOTONIC));
      pending_stamps.push_back(stamp_of(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, CLK_REALTIME));
      pending_stamps.push_back(stamp_of(64'h8000_0000_0000_0000, 32'd0, CLK_UNKNOWN));
      pending_stamps.push_back(stamp_of(64'd5, 32'd1000000000, CLK_MONOTONIC));
      pending_stamps.push_back(stamp_of(64'd5, 32'hFFFF_FFFF, CLK_OTHER));
      pending_stamps.push_back(stamp_of(64'd7, 32'd123, CLK_UNKNOWN));
      pending_stamps.push_back(stamp_of(64'd7, 32'd123, CLK_OTHER));
      pending_stamps.push_back(stamp_of(64'd7, 32'd123, CLK_MONOTONIC));
      wait_drained();

      // Largest positive offset: unknown maps to realtime, monotonic overflows or leaves range.
      write_host_pair(POLICY_REALTIME, SOURCE_NS_MAX, 64'd0, 64'h8000_0000_0000_0000, 64'd1);
      pending_stamps.push_back(stamp_of(64'd0, 32'd0, CLK_UNKNOWN));
      pending_stamps.push_back(stamp_of(64'd0, 32'd0, CLK_MONOTONIC));
      pending_stamps.push_back(stamp_of(64'd1, 32'd0, CLK_MONOTONIC));
      wait_drained();

      // Largest negative offset: the largest source maps exactly to zero, one less goes negative.
      write_host_pair(POLICY_MONOTONIC, 64'd0, SOURCE_NS_MAX, 64'd0, 64'd1);
      pending_stamps.push_back(stamp_of(64'd9223372036, 32'd854775807, CLK_UNKNOWN));
      pending_stamps.push_back(stamp_of(64'd9223372036, 32'd854775806, CLK_MONOTONIC));
      wait_drained();

      // Spare policy value behaves as reject; a small offset lands on the top of the range.
      write_host_pair(POLICY_SPARE, 64'd1000, 64'd0, 64'd12345, 64'd1);
      pending_stamps.push_back(stamp_of(64'd4294967295, 32'd999998999, CLK_MONOTONIC));
      pending_stamps.push_back(stamp_of(64'd4294967295, 32'd999999000, CLK_MONOTONIC));
      pending_stamps.push_back(stamp_of(64'd3, 32'd3, CLK_UNKNOWN));
      wait_drained();
      write_csr(CSR_INDEX_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Offsets are mostly kept small so that monotonic stamps map into range; the upper bits
         // of all writes but the uncertainty are random, which also exercises the register masking.
         kind = $urandom_range(0, 3);
         step = $urandom;
         monotonic_w = {$urandom, $urandom};
         case (kind)
            0:       realtime_w = monotonic_w + {{32{step[31]}}, step};
            1:       realtime_w = monotonic_w + {24'b0, step, 8'b0};
            2:       realtime_w = {$urandom, $urandom};
            default: realtime_w = monotonic_w - {24'b0, step, 8'b0};
         endcase
         case ($urandom_range(0, 3))
            0:       uncertainty_w = 64'd0;
            1:       uncertainty_w = 64'h8000_0000_0000_0000;
            default: uncertainty_w = {$urandom, $urandom} >> 1;
         endcase
         sample_w = {$urandom, $urandom};
         sample_w[0] = ($urandom_range(0, 4) != 0);
         write_csr(CSR_UNKNOWN_POLICY, {$urandom, $urandom});
         write_csr(CSR_HOST_REALTIME_NS, realtime_w);
         write_csr(CSR_HOST_MONOTONIC_NS, monotonic_w);
         write_csr(CSR_HOST_UNCERTAINTY_NS, uncertainty_w);
         write_csr(CSR_HOST_SAMPLE_OK, sample_w);
         // One phase runs back to back on both sides.
         gapless = (phase == 3);
         for (int n = 0; n < STAMPS_PER_PHASE; n++) begin
            pending_stamps.push_back(random_stamp());
         end
         wait_drained();
         gapless = 1'b0;
      end

      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && expected_maps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
sv/tcm_pkg.sv
sv/timestamp_clock_mapper.sv
sv/tcm_checker.sv
bench/timestamp_clock_mapper_test.sv
